@@ hw/rtl/rdp_pkg.sv @@
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared types, constants and small lookup functions for the radix digit
// emitter with palindrome flag.
// ----------------------------------------------------------------------------
package rdp_pkg;

  // Field widths
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 5;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned RECIP_W = 32;
  localparam int unsigned PROD_W  = VALUE_W + RECIP_W;

  // Digit store depth default
  localparam int unsigned MAX_DIGITS = 32;

  // Job queue depth between front and back
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Radix limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd20;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  // ASCII anchors
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 5'd10;

  // One queued conversion job
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] base;
  } job_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_COR,
    BK_EMIT
  } back_state_e;

  // floor(2^32 / base); quotient estimate is exact or one low
  function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] base);
    logic [RECIP_W-1:0] m;
    case (base)
      5'd2:    m = 32'd2147483648;
      5'd3:    m = 32'd1431655765;
      5'd4:    m = 32'd1073741824;
      5'd5:    m = 32'd858993459;
      5'd6:    m = 32'd715827882;
      5'd7:    m = 32'd613566756;
      5'd8:    m = 32'd536870912;
      5'd9:    m = 32'd477218588;
      5'd10:   m = 32'd429496729;
      5'd11:   m = 32'd390451572;
      5'd12:   m = 32'd357913941;
      5'd13:   m = 32'd330382099;
      5'd14:   m = 32'd306783378;
      5'd15:   m = 32'd286331153;
      5'd16:   m = 32'd268435456;
      5'd17:   m = 32'd252645135;
      5'd18:   m = 32'd238609294;
      5'd19:   m = 32'd226050910;
      default: m = 32'd214748364;
    endcase
    return m;
  endfunction

  // Map a digit to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + {2'b00, d};
    end else begin
      c = CHAR_A + {2'b00, d - DIGIT_TEN};
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/rdp_ram.sv @@
// ----------------------------------------------------------------------------
// rdp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/rdp_front.sv @@
// ----------------------------------------------------------------------------
// rdp_front
// Holds the radix register, accepts start commands and pushes each value
// with its clamped base into the job queue.
// ----------------------------------------------------------------------------
module rdp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rdp_pkg::RADIX_W-1:0]   cfg_radix_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [rdp_pkg::VALUE_W-1:0]   value_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output rdp_pkg::job_t                 job_o
);

  logic [rdp_pkg::RADIX_W-1:0] radix_q, radix_d;
  logic [rdp_pkg::RADIX_W-1:0] base;

  // Radix register write
  assign cfg_ready_o = 1'b1;
  always_comb begin
    radix_d = radix_q;
    if (cfg_valid_i && cfg_ready_o) begin
      radix_d = cfg_radix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rdp_pkg::RADIX_RESET;
    end else begin
      radix_q <= radix_d;
    end
  end

  // Clamp base into the supported range
  always_comb begin
    base = radix_q;
    if (radix_q < rdp_pkg::RADIX_MIN) begin
      base = rdp_pkg::RADIX_MIN;
    end else if (radix_q > rdp_pkg::RADIX_MAX) begin
      base = rdp_pkg::RADIX_MAX;
    end
  end

  // Accept a transaction whenever the queue has room
  assign busy_o      = q_full_i;
  assign push_o      = start_i && !q_full_i;
  assign job_o.value = value_i;
  assign job_o.base  = base;

endmodule

@@ hw/rtl/rdp_queue.sv @@
// ----------------------------------------------------------------------------
// rdp_queue
// Short FIFO of conversion jobs between the front and back ends.
// ----------------------------------------------------------------------------
module rdp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rdp_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rdp_pkg::job_t job_o
);

  rdp_pkg::job_t                  slot_q [rdp_pkg::QDEPTH];
  logic [rdp_pkg::QPTR_W-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [rdp_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == rdp_pkg::QCNT_W'(rdp_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = slot_q[rptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == rdp_pkg::QPTR_W'(rdp_pkg::QDEPTH - 1)) ? '0
                                                                 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == rdp_pkg::QPTR_W'(rdp_pkg::QDEPTH - 1)) ? '0
                                                                 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store pushed job
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= job_i;
    end
  end

endmodule

@@ hw/rtl/rdp_back.sv @@
// ----------------------------------------------------------------------------
// rdp_back
// Converts one queued job at a time: reciprocal-multiply division into the
// digit store, then emits digits most significant first while comparing
// the mirrored digit for the palindrome flag.
// ----------------------------------------------------------------------------
module rdp_back #(
  parameter int unsigned MaxDigits = rdp_pkg::MAX_DIGITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  rdp_pkg::job_t                job_i,
  output logic                         pop_o,
  output logic                         result_valid_o,
  output logic [rdp_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                         last_o,
  output logic                         palindrome_o
);

  localparam int unsigned AddrW = $clog2(MaxDigits);
  localparam int unsigned CntW  = $clog2(MaxDigits + 1);
  localparam int unsigned QbW   = rdp_pkg::VALUE_W + rdp_pkg::RADIX_W;

  rdp_pkg::back_state_e state_q, state_d;

  logic [rdp_pkg::VALUE_W-1:0] val_q;
  logic [rdp_pkg::RADIX_W-1:0] base_q;
  logic [rdp_pkg::RECIP_W-1:0] recip_q;
  logic [rdp_pkg::PROD_W-1:0]  prod_q;
  logic [CntW-1:0]             cnt_q, k_q;

  // Control outputs of the sequencer
  logic load, mul_en, cor_en, emit;

  // Correction step
  logic [rdp_pkg::VALUE_W-1:0] q_est, q_fix;
  logic [QbW-1:0]              qb;
  logic [QbW-1:0]              rem_full;
  logic [rdp_pkg::DIGIT_W:0]   rem0;
  logic                        rem_ge;
  logic [rdp_pkg::DIGIT_W-1:0] rem_fix;
  logic [CntW-1:0]             cnt_inc;
  logic                        div_done;

  // Emission
  logic [CntW-1:0]             cnt_m1, addr_hi;
  logic                        emit_last;
  logic [rdp_pkg::DIGIT_W-1:0] rdata_a, rdata_b;
  logic                        rd_valid_q, rd_last_q, rd_first_q;
  logic                        pal_acc_q, pal_acc_d;
  logic                        out_valid_q, out_last_q, out_pal_q;
  logic [rdp_pkg::CHAR_W-1:0]  out_char_q;

  // Divide step: estimate is exact or one low
  assign q_est    = prod_q[rdp_pkg::PROD_W-1 -: rdp_pkg::VALUE_W];
  assign qb       = q_est * base_q;
  assign rem_full = {{rdp_pkg::RADIX_W{1'b0}}, val_q} - qb;
  assign rem0     = rem_full[rdp_pkg::DIGIT_W:0];
  assign rem_ge   = (rem0 >= {1'b0, base_q});
  assign q_fix    = q_est + {{(rdp_pkg::VALUE_W-1){1'b0}}, rem_ge};
  assign rem_fix  = rem_ge ? rem0[rdp_pkg::DIGIT_W-1:0] - base_q
                           : rem0[rdp_pkg::DIGIT_W-1:0];
  assign cnt_inc  = cnt_q + 1'b1;
  assign div_done = (q_fix == '0) || (cnt_inc == CntW'(MaxDigits));

  // Read addresses for emission
  assign cnt_m1    = cnt_q - 1'b1;
  assign addr_hi   = cnt_m1 - k_q;
  assign emit_last = (k_q == cnt_m1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rdp_pkg::BK_IDLE: begin
        if (!q_empty_i) state_d = rdp_pkg::BK_MUL;
      end
      rdp_pkg::BK_MUL: begin
        state_d = rdp_pkg::BK_COR;
      end
      rdp_pkg::BK_COR: begin
        state_d = div_done ? rdp_pkg::BK_EMIT : rdp_pkg::BK_MUL;
      end
      rdp_pkg::BK_EMIT: begin
        if (emit_last) state_d = rdp_pkg::BK_IDLE;
      end
      default: state_d = rdp_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    load   = 1'b0;
    mul_en = 1'b0;
    cor_en = 1'b0;
    emit   = 1'b0;
    case (state_q)
      rdp_pkg::BK_IDLE: load   = !q_empty_i;
      rdp_pkg::BK_MUL:  mul_en = 1'b1;
      rdp_pkg::BK_COR:  cor_en = 1'b1;
      rdp_pkg::BK_EMIT: emit   = 1'b1;
      default: ;
    endcase
  end

  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdp_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of the division loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      cnt_q <= '0;
      k_q   <= '0;
    end else begin
      if (load) begin
        val_q <= job_i.value;
        cnt_q <= '0;
      end else if (cor_en) begin
        val_q <= div_done ? '0 : q_fix;
        cnt_q <= cnt_inc;
        k_q   <= '0;
      end else if (emit) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      base_q  <= job_i.base;
      recip_q <= rdp_pkg::recip(job_i.base);
    end
    if (mul_en) begin
      prod_q <= val_q * recip_q;
    end
  end

  // Two mirrored copies of the digit store, one read port each
  rdp_ram #(
    .Width (rdp_pkg::DIGIT_W),
    .Depth (MaxDigits)
  ) u_store_hi (
    .clk_i   (clk_i),
    .we_i    (cor_en),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (rem_fix),
    .re_i    (emit),
    .raddr_i (addr_hi[AddrW-1:0]),
    .rdata_o (rdata_a)
  );

  rdp_ram #(
    .Width (rdp_pkg::DIGIT_W),
    .Depth (MaxDigits)
  ) u_store_lo (
    .clk_i   (clk_i),
    .we_i    (cor_en),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (rem_fix),
    .re_i    (emit),
    .raddr_i (k_q[AddrW-1:0]),
    .rdata_o (rdata_b)
  );

  // Fold mirrored digit compare into the running palindrome flag
  assign pal_acc_d = (rd_first_q ? 1'b1 : pal_acc_q) && (rdata_a == rdata_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      rd_first_q  <= 1'b0;
      pal_acc_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_pal_q   <= 1'b0;
    end else begin
      rd_valid_q  <= emit;
      rd_last_q   <= emit && emit_last;
      rd_first_q  <= emit && (k_q == '0);
      if (rd_valid_q) begin
        pal_acc_q <= pal_acc_d;
      end
      out_valid_q <= rd_valid_q;
      out_last_q  <= rd_valid_q && rd_last_q;
      out_pal_q   <= rd_valid_q && rd_last_q && pal_acc_d;
    end
  end

  // Output character register
  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      out_char_q <= rdp_pkg::digit_to_char(rdata_a);
    end
  end

  assign result_valid_o = out_valid_q;
  assign digit_char_o   = out_char_q;
  assign last_o         = out_last_q;
  assign palindrome_o   = out_pal_q;

endmodule

@@ hw/rtl/radix_digits_with_palindrome_flag.sv @@
// Each start transaction pushes a job; when the back end is free it loads the
// job, runs the reciprocal multiply and correction states once per digit, then
// emits one digit per cycle through the digit store read register and output
// register. The back end converts one value at a time; the queue holds two.
// Results are strobed for one cycle; the receiver cannot stall. Reset sets
// radix to 10 and empties the job queue; the digit store is not cleared.
// ----------------------------------------------------------------------------
// radix_digits_with_palindrome_flag
// Converts each value to digits in the configured base, emitting ASCII
// digits most significant first with last and palindrome flags.
// ----------------------------------------------------------------------------
module radix_digits_with_palindrome_flag #(
  parameter int unsigned MaxDigits = rdp_pkg::MAX_DIGITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rdp_pkg::RADIX_W-1:0]  cfg_radix_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [rdp_pkg::VALUE_W-1:0]  value_i,
  output logic                         result_valid_o,
  output logic [rdp_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                         last_o,
  output logic                         palindrome_o
);

  logic          push, pop, q_full, q_empty;
  rdp_pkg::job_t job_in, job_out;

  rdp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_radix_i (cfg_radix_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .value_i     (value_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (job_in)
  );

  rdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .job_o   (job_out)
  );

  rdp_back #(
    .MaxDigits (MaxDigits)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .job_i          (job_out),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .digit_char_o   (digit_char_o),
    .last_o         (last_o),
    .palindrome_o   (palindrome_o)
  );

endmodule
